>>> rtl/dsa_pkg.sv
`default_nettype none
package dsa_pkg;

   localparam int PTR_W  = 13;
   localparam int HDR_W  = 26;
   localparam int CALC_W = 18;
   localparam int MASK_W = 16;

   localparam logic [PTR_W-1:0] ARENA_SIZE_RESET = 13'd4096;

   // register index, taken from paddr[2]
   localparam logic CSR_ARENA_SIZE = 1'b0;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   typedef enum logic [2:0] {
      FUNC_ALLOC_FRONT = 3'd0,
      FUNC_ALLOC_BACK  = 3'd1,
      FUNC_FREE_FRONT  = 3'd2,
      FUNC_FREE_BACK   = 3'd3,
      FUNC_RESTART     = 3'd4,
      FUNC_QUERY       = 3'd5
   } dsa_func_type;

   typedef enum logic {
      ST_ISSUE,
      ST_COMMIT
   } dsa_state_type;

   typedef struct packed {
      dsa_func_type      func;
      logic [PTR_W-1:0]  size;
      logic [MASK_W-1:0] amask;
      logic [PTR_W-1:0]  need;
      logic [PTR_W:0]    sizeh;
      logic              idx_ok;
      logic [PTR_W-1:0]  idx;
   } dsa_cmd_type;

   typedef struct packed {
      logic             restart;
      logic [PTR_W-1:0] new_end;
      logic [PTR_W-1:0] cur_end;
   } dsa_cfg_type;

endpackage
`default_nettype wire

>>> rtl/double_ended_stack_allocator.sv
// A result passes from the two-entry queue through the issue and commit states to the response
//   register. Each item takes an issue step (pointer math or header read from the header RAM)
//   and a commit step (pointer update, header write), which waits while the response is stalled.
// Reset: front pointer to 0, back pointer to the arena end, arena_size to 4096, queue and
//   result register emptied. The header RAM is not cleared.
`default_nettype none
module double_ended_stack_allocator #(
   parameter int ARENA_BYTES  = 4096,
   parameter int HEADER_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [12:0] req_size,
   input  wire logic [3:0]  req_align_log2,
   input  wire logic [11:0] req_prefix_bytes,
   input  wire logic [12:0] req_user_addr,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [12:0]      rsp_result_addr,
   output logic             rsp_status,
   output logic [12:0]      rsp_stored_size,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int AW = $clog2(ARENA_BYTES);

   logic [12:0] arena_size_ff, arena_size_in;
   logic        csr_write;
   dsa_pkg::dsa_cfg_type cfg;

   logic                 q_valid;
   dsa_pkg::dsa_cmd_type q_cmd;
   logic                 q_pop;

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [dsa_pkg::HDR_W-1:0] ram_wdata;
   logic                      ram_re;
   logic [AW-1:0]             ram_raddr;
   logic [dsa_pkg::HDR_W-1:0] ram_rdata;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[2] == dsa_pkg::CSR_ARENA_SIZE);
   assign prdata    = (paddr[2] == dsa_pkg::CSR_ARENA_SIZE) ? 32'(arena_size_ff) : 32'd0;

   assign arena_size_in = csr_write ? pwdata[12:0] : arena_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_size_ff <= dsa_pkg::ARENA_SIZE_RESET;
      end else begin
         arena_size_ff <= arena_size_in;
      end
   end

   always_comb begin
      cfg.restart = csr_write;
      cfg.new_end = (17'(pwdata[12:0]) < 17'(ARENA_BYTES)) ? pwdata[12:0] : 13'(ARENA_BYTES);
      cfg.cur_end = (17'(arena_size_ff) < 17'(ARENA_BYTES)) ? arena_size_ff
                                                            : 13'(ARENA_BYTES);
   end

   dsa_front #(
      .ARENA_BYTES  (ARENA_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_size         (req_size),
      .req_align_log2   (req_align_log2),
      .req_prefix_bytes (req_prefix_bytes),
      .req_user_addr    (req_user_addr),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop)
   );

   dsa_back #(
      .ARENA_BYTES  (ARENA_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_re          (ram_re),
      .ram_raddr       (ram_raddr),
      .ram_rdata       (ram_rdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_addr (rsp_result_addr),
      .rsp_status      (rsp_status),
      .rsp_stored_size (rsp_stored_size)
   );

   dsa_ram #(
      .WIDTH (dsa_pkg::HDR_W),
      .DEPTH (ARENA_BYTES)
   ) u_header_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule
`default_nettype wire

>>> rtl/dsa_ram.sv
`default_nettype none
module dsa_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> rtl/dsa_front.sv
`default_nettype none
module dsa_front #(
   parameter int ARENA_BYTES  = 4096,
   parameter int HEADER_BYTES = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [2:0]                   req_func,
   input  wire logic [12:0]                  req_size,
   input  wire logic [3:0]                   req_align_log2,
   input  wire logic [11:0]                  req_prefix_bytes,
   input  wire logic [12:0]                  req_user_addr,
   output logic                              q_valid,
   output dsa_pkg::dsa_cmd_type              q_cmd,
   input  wire logic                         q_pop
);

   dsa_pkg::dsa_cmd_type cmd;
   logic [dsa_pkg::MASK_W:0] amask_wide;

   dsa_pkg::dsa_cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // classify
   assign amask_wide = (17'd1 << req_align_log2) - 17'd1;

   always_comb begin
      cmd.func   = dsa_pkg::dsa_func_type'(req_func);
      cmd.size   = req_size;
      cmd.amask  = amask_wide[dsa_pkg::MASK_W-1:0];
      cmd.need   = 13'(req_prefix_bytes) + 13'(HEADER_BYTES);
      cmd.sizeh  = 14'(req_size) + 14'(HEADER_BYTES);
      cmd.idx    = req_user_addr - 13'(HEADER_BYTES);
      cmd.idx_ok = (req_user_addr >= 13'(HEADER_BYTES)) &&
                   (17'(cmd.idx) < 17'(ARENA_BYTES));
   end

   // two-entry queue
   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule
`default_nettype wire

>>> rtl/dsa_back.sv
`default_nettype none
module dsa_back #(
   parameter int ARENA_BYTES  = 4096,
   parameter int HEADER_BYTES = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire dsa_pkg::dsa_cfg_type               cfg,
   input  wire logic                               q_valid,
   input  wire dsa_pkg::dsa_cmd_type               q_cmd,
   output logic                                    q_pop,
   output logic                                    ram_we,
   output logic [$clog2(ARENA_BYTES)-1:0]          ram_waddr,
   output logic [dsa_pkg::HDR_W-1:0]               ram_wdata,
   output logic                                    ram_re,
   output logic [$clog2(ARENA_BYTES)-1:0]          ram_raddr,
   input  wire logic [dsa_pkg::HDR_W-1:0]          ram_rdata,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [12:0]                             rsp_result_addr,
   output logic                                    rsp_status,
   output logic [12:0]                             rsp_stored_size
);

   localparam int AW = $clog2(ARENA_BYTES);
   localparam int CW = dsa_pkg::CALC_W;
   localparam logic [12:0] RESET_END =
      13'((ARENA_BYTES < 4096) ? ARENA_BYTES : 4096);

   dsa_pkg::dsa_state_type state_ff, state_in;
   dsa_pkg::dsa_cmd_type   cmd_ff, cmd_in;
   logic [CW-1:0] sum_ff, sum_in;
   logic          fail_ff, fail_in;
   logic [12:0]   front_ff, front_in;
   logic [12:0]   back_ff, back_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [12:0]   rsp_addr_ff, rsp_addr_in;
   logic          rsp_status_ff, rsp_status_in;
   logic [12:0]   rsp_size_ff, rsp_size_in;

   logic          out_free;
   logic [CW-1:0] f_h;
   logic          f_fail;
   logic [CW-1:0] b_h;
   logic          b_fail;
   logic [12:0]   b_prev;
   logic [12:0]   rd_off;
   logic [12:0]   fb_back;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign f_h    = (sum_ff & ~{2'b00, cmd_ff.amask}) - CW'(cmd_ff.need);
   assign f_fail = ((f_h + CW'(cmd_ff.sizeh)) > CW'(back_ff)) ||
                   (f_h >= CW'(ARENA_BYTES));

   assign b_h    = sum_ff - CW'(cmd_ff.need);
   assign b_fail = fail_ff || (sum_ff < CW'(cmd_ff.need)) ||
                   (b_h < CW'(front_ff)) || (b_h >= CW'(ARENA_BYTES));
   assign b_prev = (cfg.cur_end >= back_ff) ? cfg.cur_end - back_ff : 13'd0;

   assign rd_off  = ram_rdata[12:0];
   assign fb_back = (rd_off <= cfg.cur_end) ? cfg.cur_end - rd_off : 13'd0;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      sum_in        = sum_ff;
      fail_in       = fail_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_size_in   = rsp_size_ff;
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = AW'(f_h);
      ram_wdata     = {cmd_ff.size, front_ff};
      ram_re        = 1'b0;
      ram_raddr     = AW'(q_cmd.idx);

      case (state_ff)
         dsa_pkg::ST_ISSUE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = dsa_pkg::ST_COMMIT;
               if (q_cmd.func == dsa_pkg::FUNC_ALLOC_BACK) begin
                  fail_in = q_cmd.size > back_ff;
                  sum_in  = CW'((back_ff - q_cmd.size) & ~q_cmd.amask[12:0]);
               end else begin
                  fail_in = 1'b0;
                  sum_in  = CW'(front_ff) + CW'(q_cmd.need) + CW'(q_cmd.amask);
               end
               ram_re = q_cmd.idx_ok && (q_cmd.func inside {dsa_pkg::FUNC_FREE_FRONT,
                        dsa_pkg::FUNC_FREE_BACK, dsa_pkg::FUNC_QUERY});
            end
         end
         dsa_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in      = dsa_pkg::ST_ISSUE;
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = 13'd0;
               rsp_status_in = dsa_pkg::STATUS_OK;
               rsp_size_in   = 13'd0;
               case (cmd_ff.func)
                  dsa_pkg::FUNC_ALLOC_FRONT: begin
                     if (f_fail) begin
                        rsp_status_in = dsa_pkg::STATUS_NO_SPACE;
                     end else begin
                        ram_we      = 1'b1;
                        ram_waddr   = AW'(f_h);
                        ram_wdata   = {cmd_ff.size, front_ff};
                        rsp_addr_in = 13'(f_h + CW'(HEADER_BYTES));
                        front_in    = 13'(f_h + CW'(cmd_ff.sizeh));
                     end
                  end
                  dsa_pkg::FUNC_ALLOC_BACK: begin
                     if (b_fail) begin
                        rsp_status_in = dsa_pkg::STATUS_NO_SPACE;
                     end else begin
                        ram_we      = 1'b1;
                        ram_waddr   = AW'(b_h);
                        ram_wdata   = {cmd_ff.size, b_prev};
                        rsp_addr_in = 13'(b_h + CW'(HEADER_BYTES));
                        back_in     = 13'(b_h);
                     end
                  end
                  dsa_pkg::FUNC_FREE_FRONT: begin
                     if (cmd_ff.idx_ok) begin
                        front_in = rd_off;
                     end
                  end
                  dsa_pkg::FUNC_FREE_BACK: begin
                     if (cmd_ff.idx_ok) begin
                        back_in = fb_back;
                     end
                  end
                  dsa_pkg::FUNC_RESTART: begin
                     front_in = 13'd0;
                     back_in  = cfg.cur_end;
                  end
                  dsa_pkg::FUNC_QUERY: begin
                     if (cmd_ff.idx_ok) begin
                        rsp_size_in = ram_rdata[25:13];
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = dsa_pkg::ST_ISSUE;
      endcase

      if (cfg.restart) begin
         front_in = 13'd0;
         back_in  = cfg.new_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsa_pkg::ST_ISSUE;
         rsp_valid_ff <= 1'b0;
         front_ff     <= 13'd0;
         back_ff      <= RESET_END;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      sum_ff        <= sum_in;
      fail_ff       <= fail_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_stored_size = rsp_size_ff;

endmodule
`default_nettype wire
